FILE: rtl/bac_pkg.sv
package bac_pkg;

  localparam int WINDOW = 8;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 24;
  localparam int TOT_W = SAMPLE_W + $clog2(WINDOW);
  localparam int DIVD_W = 48;
  localparam int DIVS_W = 24;
  localparam int SCALE_W = 23;
  localparam int STEP_W = 5;

  typedef enum logic [2:0] {
    REG_C0_C1   = 3'd0,
    REG_C00_C10 = 3'd1,
    REG_C01_C11 = 3'd2,
    REG_C20_C21 = 3'd3,
    REG_C30     = 3'd4,
    REG_PSCALE  = 3'd5,
    REG_TSCALE  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
    logic [SCALE_W-1:0] p_scale;
    logic [SCALE_W-1:0] t_scale;
  } coef_t;

  typedef struct packed {
    logic signed [TOT_W-1:0] p_total;
    logic signed [TOT_W-1:0] t_total;
    logic [CNT_W-1:0] fill;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic not_empty;
  } queue_ctl_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[47:0];
    if (v < lo) return lo[47:0];
    return v[47:0];
  endfunction

endpackage

FILE: rtl/bac_div.sv
module bac_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [bac_pkg::DIVD_W-1:0] dividend,
  input  logic [bac_pkg::DIVS_W-1:0] divisor,
  output logic done,
  output logic [bac_pkg::DIVD_W-1:0] quotient
);
  import bac_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic [CW-1:0] count;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0] shifted;
  logic [DIVS_W+1:0] diff;

  assign shifted = {rem, quotient[DIVD_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (count == CW'(1));
      if (start) begin
        count <= CW'(DIVD_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (count != '0) begin
      if (!diff[DIVS_W+1]) begin
        rem <= diff[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/bac_front.sv
module bac_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [bac_pkg::SAMPLE_W-1:0] pressure_sample,
  input  logic signed [bac_pkg::SAMPLE_W-1:0] temperature_sample,
  input  logic q_full,
  output logic q_push,
  output bac_pkg::entry_t q_data
);
  import bac_pkg::*;

  logic signed [SAMPLE_W-1:0] p_ring [WINDOW];
  logic signed [SAMPLE_W-1:0] t_ring [WINDOW];
  logic signed [TOT_W-1:0] p_total, p_total_next;
  logic signed [TOT_W-1:0] t_total, t_total_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [SLOT_W-1:0] oldest, oldest_next;
  logic [SLOT_W-1:0] slot;
  logic filling;

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready;
  assign filling = fill < CNT_W'(WINDOW);
  assign slot = filling ? fill[SLOT_W-1:0] : oldest;

  always_comb begin
    p_total_next = p_total + TOT_W'(pressure_sample);
    t_total_next = t_total + TOT_W'(temperature_sample);
    fill_next = fill;
    oldest_next = oldest;
    if (filling) begin
      fill_next = fill + 1'b1;
    end else begin
      p_total_next = p_total_next - TOT_W'(p_ring[oldest]);
      t_total_next = t_total_next - TOT_W'(t_ring[oldest]);
      oldest_next = (oldest == SLOT_W'(WINDOW - 1)) ? '0 : oldest + 1'b1;
    end
  end

  assign q_data.p_total = p_total_next;
  assign q_data.t_total = t_total_next;
  assign q_data.fill = fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_total <= '0;
      t_total <= '0;
      fill <= '0;
      oldest <= '0;
    end else if (q_push) begin
      p_total <= p_total_next;
      t_total <= t_total_next;
      fill <= fill_next;
      oldest <= oldest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      p_ring[slot] <= pressure_sample;
      t_ring[slot] <= temperature_sample;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW)) else $error("fill count beyond window");
  a_oldest_fill: assert property (@(posedge clk) disable iff (rst)
    filling |-> oldest == '0) else $error("oldest slot moved while filling");
`endif

endmodule

FILE: rtl/bac_queue.sv
module bac_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic pop,
  input  bac_pkg::entry_t wr_data,
  output bac_pkg::entry_t rd_data,
  output bac_pkg::queue_ctl_t ctl
);
  import bac_pkg::*;

  entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign rd_data = slots[rd_ptr];
  assign ctl.push = push;
  assign ctl.pop = pop;
  assign ctl.full = count == 2'd2;
  assign ctl.not_empty = count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

endmodule

FILE: rtl/bac_back.sv
module bac_back (
  input  logic clk,
  input  logic rst,
  input  bac_pkg::coef_t coef,
  input  logic q_valid,
  input  bac_pkg::entry_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [23:0] pressure_average,
  output logic signed [23:0] temperature_average,
  output logic signed [23:0] temperature_q8,
  output logic signed [31:0] pressure_q8
);
  import bac_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AVG   = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_FRAC  = 6'b001000,
    ST_POLY  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;

  logic p_start, t_start, p_done, t_done;
  logic [DIVD_W-1:0] p_dvd, t_dvd, p_quo, t_quo;
  logic [DIVS_W-1:0] p_dsr, t_dsr;
  logic p_neg, t_neg;
  logic [TOT_W-1:0] p_mag, t_mag;
  logic [23:0] p_amag, t_amag;

  logic signed [23:0] p_avg, t_avg;
  logic signed [31:0] pf, tf;
  logic signed [24:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [56:0] prod, hi;
  logic signed [47:0] acc, h_reg, g_reg, t_reg;
  logic signed [47:0] acc_sat;
  logic signed [23:0] tq8;
  logic signed [31:0] pq8;
  logic signed [57:0] sum58;
  logic signed [63:0] sum64, prod64, acc_sat64, t24, p24, sh;

  assign q_pop = (state == ST_IDLE) && q_valid;

  assign p_mag = q_data.p_total[TOT_W-1] ? -q_data.p_total : q_data.p_total;
  assign t_mag = q_data.t_total[TOT_W-1] ? -q_data.t_total : q_data.t_total;
  assign p_amag = p_avg[23] ? -p_avg : p_avg;
  assign t_amag = t_avg[23] ? -t_avg : t_avg;

  always_comb begin
    p_start = 1'b0;
    t_start = 1'b0;
    p_dvd = {p_amag, 24'b0};
    t_dvd = {t_amag, 24'b0};
    p_dsr = (coef.p_scale == '0) ? DIVS_W'(1) : DIVS_W'(coef.p_scale);
    t_dsr = (coef.t_scale == '0) ? DIVS_W'(1) : DIVS_W'(coef.t_scale);
    if (q_pop) begin
      p_start = 1'b1;
      t_start = 1'b1;
      p_dvd = DIVD_W'(p_mag);
      t_dvd = DIVD_W'(t_mag);
      p_dsr = DIVS_W'(q_data.fill);
      t_dsr = DIVS_W'(q_data.fill);
    end else if (state == ST_SCALE) begin
      p_start = 1'b1;
      t_start = 1'b1;
    end
  end

  bac_div u_p_div (.clk, .rst, .start(p_start), .dividend(p_dvd), .divisor(p_dsr),
    .done(p_done), .quotient(p_quo));
  bac_div u_t_div (.clk, .rst, .start(t_start), .dividend(t_dvd), .divisor(t_dsr),
    .done(t_done), .quotient(t_quo));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step) inside
      5'd0: begin mul_a = 25'(coef.c1); mul_b = tf; end
      5'd1: begin mul_a = 25'(coef.c30); mul_b = pf; end
      5'd3, 5'd6, 5'd10: begin mul_a = {acc[47], acc[47:24]}; mul_b = pf; end
      5'd4, 5'd7, 5'd11: begin mul_a = {1'b0, acc[23:0]}; mul_b = pf; end
      5'd8: begin mul_a = 25'(coef.c21); mul_b = pf; end
      5'd13: begin mul_a = {acc[47], acc[47:24]}; mul_b = tf; end
      5'd14: begin mul_a = {1'b0, acc[23:0]}; mul_b = tf; end
      5'd15: begin mul_a = 25'(coef.c01); mul_b = tf; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sum58 = {hi[56], hi} + {{25{prod[56]}}, prod[56:24]};
  assign sum64 = {{6{sum58[57]}}, sum58};
  assign prod64 = {{7{prod[56]}}, prod};
  assign acc_sat = sat48(sum64);
  assign acc_sat64 = {{16{acc_sat[47]}}, acc_sat};
  assign t24 = {{29{coef.c0[11]}}, coef.c0, 23'b0} + prod64;
  assign p24 = {{20{coef.c00[19]}}, coef.c00, 24'b0} + {{16{h_reg[47]}}, h_reg}
             + {{16{g_reg[47]}}, g_reg} + {{16{t_reg[47]}}, t_reg};
  assign sh = (step == 5'd1) ? (t24 >>> 16) : (p24 >>> 16);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    hi <= prod;
    if (state == ST_AVG && p_done) begin
      p_avg <= p_neg ? -p_quo[23:0] : p_quo[23:0];
      t_avg <= t_neg ? -t_quo[23:0] : t_quo[23:0];
    end
    if (state == ST_SCALE) begin
      p_neg <= p_avg[23];
      t_neg <= t_avg[23];
    end
    if (q_pop) begin
      p_neg <= q_data.p_total[TOT_W-1];
      t_neg <= q_data.t_total[TOT_W-1];
    end
    if (state == ST_FRAC && p_done) begin
      if (!p_neg) pf <= (p_quo > DIVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : p_quo[31:0];
      else pf <= (p_quo > DIVD_W'(33'h8000_0000)) ? 32'sh8000_0000 : -p_quo[31:0];
      if (!t_neg) tf <= (t_quo > DIVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : t_quo[31:0];
      else tf <= (t_quo > DIVD_W'(33'h8000_0000)) ? 32'sh8000_0000 : -t_quo[31:0];
    end
    if (state == ST_POLY) begin
      case (step)
        5'd1: begin
          if (sh > 64'sd8388607) tq8 <= 24'sh7FFFFF;
          else if (sh < -64'sd8388608) tq8 <= 24'sh800000;
          else tq8 <= sh[23:0];
        end
        5'd2: acc <= sat48(prod64 + {{24{coef.c20[15]}}, coef.c20, 24'b0});
        5'd5: acc <= sat48(acc_sat64 + {{20{coef.c10[19]}}, coef.c10, 24'b0});
        5'd8: h_reg <= sat48(sum64);
        5'd9: acc <= sat48(prod64 + {{24{coef.c11[15]}}, coef.c11, 24'b0});
        5'd12: acc <= sat48(sum64);
        5'd15: g_reg <= sat48(sum64);
        5'd16: t_reg <= sat48(prod64);
        5'd17: begin
          if (sh > 64'sh7FFF_FFFF) pq8 <= 32'sh7FFF_FFFF;
          else if (sh < -64'sh8000_0000) pq8 <= 32'sh8000_0000;
          else pq8 <= sh[31:0];
        end
        default: ;
      endcase
    end
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      pressure_average <= p_avg;
      temperature_average <= t_avg;
      temperature_q8 <= tq8;
      pressure_q8 <= pq8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (q_pop) state <= ST_AVG;
        ST_AVG: if (p_done) state <= ST_SCALE;
        ST_SCALE: state <= ST_FRAC;
        ST_FRAC: if (p_done) begin
          state <= ST_POLY;
          step <= '0;
        end
        ST_POLY: begin
          step <= step + 1'b1;
          if (step == 5'd17) state <= ST_FIN;
        end
        ST_FIN: if (!out_valid || out_ready) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    p_done == t_done) else $error("divider lanes out of step");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_AVG) else $error("pop did not start averaging");
`endif

endmodule

FILE: rtl/baro_average_and_compensate_unit.sv
// An input transaction reaches result valid through two 48-step
// bit-serial dividers run twice (average, then scaling) and an
// 18-step polynomial sequencer around one shared 25x32 multiplier.
// The back end handles one transaction at a time while a two-entry
// queue buffers inputs. Synchronous active-high reset clears totals,
// fill count, queue, control state, c-coefficients; presets the scales.
module baro_average_and_compensate_unit (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [5:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [23:0] pressure_sample,
  input  logic signed [23:0] temperature_sample,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [23:0] pressure_average,
  output logic signed [23:0] temperature_average,
  output logic signed [23:0] temperature_q8,
  output logic signed [31:0] pressure_q8
);
  import bac_pkg::*;

  logic [23:0] r_c0_c1;
  logic [39:0] r_c00_c10;
  logic [31:0] r_c01_c11;
  logic [31:0] r_c20_c21;
  logic [15:0] r_c30;
  logic [SCALE_W-1:0] r_pscale;
  logic [SCALE_W-1:0] r_tscale;
  coef_t coef;
  entry_t q_wr, q_rd;
  queue_ctl_t q_ctl;
  logic q_push, q_pop;
  logic wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign idx = reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_c0_c1 <= '0;
      r_c00_c10 <= '0;
      r_c01_c11 <= '0;
      r_c20_c21 <= '0;
      r_c30 <= '0;
      r_pscale <= SCALE_W'(7864320);
      r_tscale <= SCALE_W'(524288);
    end else if (wr_en) begin
      unique case (idx)
        REG_C0_C1: r_c0_c1 <= pwdata[23:0];
        REG_C00_C10: r_c00_c10 <= pwdata[39:0];
        REG_C01_C11: r_c01_c11 <= pwdata[31:0];
        REG_C20_C21: r_c20_c21 <= pwdata[31:0];
        REG_C30: r_c30 <= pwdata[15:0];
        REG_PSCALE: r_pscale <= pwdata[SCALE_W-1:0];
        REG_TSCALE: r_tscale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_C0_C1: prdata = 64'(r_c0_c1);
      REG_C00_C10: prdata = 64'(r_c00_c10);
      REG_C01_C11: prdata = 64'(r_c01_c11);
      REG_C20_C21: prdata = 64'(r_c20_c21);
      REG_C30: prdata = 64'(r_c30);
      REG_PSCALE: prdata = 64'(r_pscale);
      REG_TSCALE: prdata = 64'(r_tscale);
      default: prdata = '0;
    endcase
  end

  assign coef.c0 = r_c0_c1[23:12];
  assign coef.c1 = r_c0_c1[11:0];
  assign coef.c00 = r_c00_c10[39:20];
  assign coef.c10 = r_c00_c10[19:0];
  assign coef.c01 = r_c01_c11[31:16];
  assign coef.c11 = r_c01_c11[15:0];
  assign coef.c20 = r_c20_c21[31:16];
  assign coef.c21 = r_c20_c21[15:0];
  assign coef.c30 = r_c30;
  assign coef.p_scale = r_pscale;
  assign coef.t_scale = r_tscale;

  bac_front u_front (
    .clk, .rst, .in_valid, .in_ready, .pressure_sample, .temperature_sample,
    .q_full(q_ctl.full), .q_push, .q_data(q_wr)
  );

  bac_queue u_queue (
    .clk, .rst, .push(q_push), .pop(q_pop), .wr_data(q_wr), .rd_data(q_rd), .ctl(q_ctl)
  );

  bac_back u_back (
    .clk, .rst, .coef, .q_valid(q_ctl.not_empty), .q_data(q_rd), .q_pop,
    .out_valid, .out_ready, .pressure_average, .temperature_average,
    .temperature_q8, .pressure_q8
  );

endmodule
